### rtl/sle_pkg.sv
// shared constants, codes and types of the serial line editor
package sle_pkg;

  localparam int LINE_CAPACITY = 64;
  localparam int IDX_W = $clog2(LINE_CAPACITY);

  localparam int CMD_W = 2;
  localparam int BYTE_W = 8;
  localparam int RIDX_W = 6;
  localparam int LEN_W = 6;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_RX = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'h7f;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0d;

  localparam logic REG_ECHO_ENABLE = 1'b0;

  typedef struct packed {
    logic              echo_valid;
    logic [BYTE_W-1:0] echo_byte;
    logic              line_ready;
    logic [LEN_W-1:0]  line_length;
    logic [BYTE_W-1:0] read_byte;
    logic              pair;
  } sle_res_t;

endpackage

### rtl/sle_in_if.sv
// request channel into the line editor
interface sle_in_if;
  logic                      valid;
  logic                      ready;
  logic [sle_pkg::CMD_W-1:0]  cmd;
  logic [sle_pkg::BYTE_W-1:0] rx_byte;
  logic [sle_pkg::RIDX_W-1:0] read_index;

  modport source (output valid, cmd, rx_byte, read_index, input ready);
  modport sink (input valid, cmd, rx_byte, read_index, output ready);
endinterface

### rtl/sle_out_if.sv
// result channel out of the line editor
interface sle_out_if;
  logic                      valid;
  logic                      ready;
  logic                      echo_valid;
  logic [sle_pkg::BYTE_W-1:0] echo_byte;
  logic                      line_ready;
  logic [sle_pkg::LEN_W-1:0]  line_length;
  logic [sle_pkg::BYTE_W-1:0] read_byte;
  logic                      last;

  modport source (output valid, echo_valid, echo_byte, line_ready, line_length, read_byte,
                  last, input ready);
  modport sink (input valid, echo_valid, echo_byte, line_ready, line_length, read_byte,
                last, output ready);
endinterface

### rtl/serial_line_input_editor_core.sv
// top level of the serial line editor with backspace and echo
// Builds a command line of up to 63 characters from received bytes and answers clear and
// read requests. A request is taken every clock cycle while the result path does not stall;
// its state change is made at the accepting edge, and the line store is read into a register
// there. Its result is kept in a holding register until it is loaded into the output
// register, from which it is offered on the result channel. Each request gives one result,
// except an echoed line end, which gives two (cr, then lf). While a line is pending,
// received bytes are dropped. A clear request empties the line at once; there is no
// clearing pass after reset. Echo is switched by the register at byte address 0 of the apb
// port.
module serial_line_input_editor_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sle_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sle_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sle_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  sle_in_if.sink                         item,
  sle_out_if.source                      result
);

  logic              echo_enable;
  logic              pvalid;
  logic              take;
  sle_pkg::sle_res_t pres;

  sle_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .echo_enable (echo_enable)
  );

  sle_core u_core (
    .clk         (clk),
    .rst         (rst),
    .echo_enable (echo_enable),
    .item        (item),
    .pvalid      (pvalid),
    .pres        (pres),
    .take        (take)
  );

  sle_out u_out (
    .clk    (clk),
    .rst    (rst),
    .pvalid (pvalid),
    .pres   (pres),
    .take   (take),
    .result (result)
  );

endmodule

### rtl/sle_cfg.sv
// apb register block holding the echo enable
module sle_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sle_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sle_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sle_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic                           echo_enable
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b0;
    end else if (wr && (paddr[2] == sle_pkg::REG_ECHO_ENABLE)) begin
      echo_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == sle_pkg::REG_ECHO_ENABLE) begin
      prdata[0] = echo_enable;
    end
  end

endmodule

### rtl/sle_core.sv
// line state, line store and registered decode of each request
module sle_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              echo_enable,
  sle_in_if.sink            item,
  output logic              pvalid,
  output sle_pkg::sle_res_t pres,
  input  logic              take
);

  logic [sle_pkg::IDX_W-1:0]         widx;
  logic [sle_pkg::IDX_W-1:0]         idx_next;
  logic                              full;
  logic                              full_next;
  logic [sle_pkg::LINE_CAPACITY-1:0] vld;
  logic [sle_pkg::BYTE_W-1:0]        mem [sle_pkg::LINE_CAPACITY];
  logic [sle_pkg::BYTE_W-1:0]        rdata;
  logic [sle_pkg::IDX_W-1:0]         ridx;
  logic                              in_range;
  logic                              hit;
  logic                              phit;
  logic                              clr;
  logic                              wr_en;
  logic                              wr_vld;
  logic                              accept;
  logic                              is_bs;
  logic                              is_put;
  logic                              is_end;
  sle_pkg::sle_res_t                 r;
  sle_pkg::sle_res_t                 preg;

  assign item.ready = !pvalid || take;
  assign accept = item.valid && item.ready;
  assign ridx = sle_pkg::IDX_W'(item.read_index);
  assign in_range = int'(item.read_index) < sle_pkg::LINE_CAPACITY;

  assign is_bs = ((item.rx_byte == sle_pkg::CH_BS) || (item.rx_byte == sle_pkg::CH_DEL))
                 && (widx != '0);
  assign is_put = !is_bs && (item.rx_byte >= sle_pkg::CH_SPACE)
                  && (widx < sle_pkg::IDX_W'(sle_pkg::LINE_CAPACITY - 1));
  assign is_end = !is_bs && !is_put
                  && ((item.rx_byte == sle_pkg::CH_LF) || (item.rx_byte == sle_pkg::CH_CR));

  always_comb begin
    idx_next = widx;
    full_next = full;
    clr = 1'b0;
    wr_en = 1'b0;
    wr_vld = 1'b0;
    hit = 1'b0;
    r = '0;
    unique case (item.cmd)
      sle_pkg::CMD_CLEAR: begin
        clr = 1'b1;
        idx_next = '0;
        full_next = 1'b0;
      end
      sle_pkg::CMD_READ: begin
        hit = in_range && vld[ridx];
      end
      sle_pkg::CMD_RX: begin
        if (!full) begin
          if (is_bs) begin
            idx_next = widx - sle_pkg::IDX_W'(1);
            r.echo_valid = echo_enable;
            r.echo_byte = echo_enable ? sle_pkg::CH_BS : '0;
          end else if (is_put) begin
            idx_next = widx + sle_pkg::IDX_W'(1);
            wr_en = 1'b1;
            wr_vld = 1'b1;
            r.echo_valid = echo_enable;
            r.echo_byte = echo_enable ? item.rx_byte : '0;
          end else if (is_end) begin
            wr_en = 1'b1;
            full_next = 1'b1;
            r.echo_valid = echo_enable;
            r.pair = echo_enable;
          end
        end
      end
      default: ;
    endcase
    r.line_ready = full_next;
    r.line_length = sle_pkg::LEN_W'(idx_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      widx <= '0;
      full <= 1'b0;
      vld <= '0;
      pvalid <= 1'b0;
    end else begin
      if (accept) begin
        widx <= idx_next;
        full <= full_next;
        if (clr) begin
          vld <= '0;
        end else if (wr_en) begin
          vld[widx] <= wr_vld;
        end
      end
      if (accept) begin
        pvalid <= 1'b1;
      end else if (take) begin
        pvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      preg <= r;
      phit <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en && wr_vld) begin
      mem[widx] <= item.rx_byte;
    end
    if (accept) begin
      rdata <= mem[ridx];
    end
  end

  always_comb begin
    pres = preg;
    pres.read_byte = phit ? rdata : '0;
  end

endmodule

### rtl/sle_out.sv
// result register, splits an echoed line end into cr then lf
module sle_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              pvalid,
  input  sle_pkg::sle_res_t pres,
  output logic              take,
  sle_out_if.source         result
);

  logic              ovalid;
  logic              olast;
  sle_pkg::sle_res_t obuf;
  sle_pkg::sle_res_t loaded;

  assign take = pvalid && (!ovalid || (result.ready && olast));

  // an echoed line end starts with cr
  always_comb begin
    loaded = pres;
    if (pres.pair) begin
      loaded.echo_byte = sle_pkg::CH_CR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (take) begin
      ovalid <= 1'b1;
    end else if (ovalid && result.ready && olast) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      obuf <= loaded;
      olast <= !pres.pair;
    end else if (ovalid && result.ready && !olast) begin
      obuf.echo_byte <= sle_pkg::CH_LF;
      olast <= 1'b1;
    end
  end

  assign result.valid = ovalid;
  assign result.echo_valid = obuf.echo_valid;
  assign result.echo_byte = obuf.echo_byte;
  assign result.line_ready = obuf.line_ready;
  assign result.line_length = obuf.line_length;
  assign result.read_byte = obuf.read_byte;
  assign result.last = olast;

endmodule
